/* rtl/core/csc_pkg.sv */
// csc_pkg: shared types and constants of the clock sweep cache
// used by csc_cell, clock_sweep_cache and csc_checker; no dependencies

package csc_pkg;

  // defaults for the top level parameters
  localparam int FRAMES_DEF     = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // fixed field widths
  localparam int CFG_BITS = 5;
  localparam int FI_BITS  = 4;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

  // action codes of an input item
  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  // control flags of the token that walks the cell row
  typedef struct packed {
    logic valid;       // token present in this stage
    logic sweep;       // replacement sweep, otherwise lookup
    logic found;       // hit (lookup) or victim (sweep) taken
    logic free_found;  // lowest free active frame recorded
  } pkt_ctl_t;

endpackage

/* rtl/core/csc_cell.sv */
// csc_cell: one frame of the clock sweep cache plus one stage of the token row
// depends on csc_pkg

module csc_cell #(
  parameter int FRAMES     = csc_pkg::FRAMES_DEF,
  parameter int KEY_BITS   = csc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = csc_pkg::VALUE_BITS_DEF,
  parameter int CELL_IDX   = 0
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [$clog2(FRAMES+1)-1:0]             act,
  input  logic                                    req_action,
  input  logic [KEY_BITS-1:0]                     req_key,
  input  logic [VALUE_BITS-1:0]                   req_value,
  input  csc_pkg::pkt_ctl_t                       inj_ctl,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] inj_at,
  input  logic                                    wr_en,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] wr_at,
  input  csc_pkg::pkt_ctl_t                       prev_ctl,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] prev_idx,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] prev_free_idx,
  input  logic [VALUE_BITS-1:0]                   prev_val,
  input  logic [KEY_BITS-1:0]                     prev_evk,
  output csc_pkg::pkt_ctl_t                       ctl_q,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] idx_q,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] free_idx_q,
  output logic [VALUE_BITS-1:0]                   val_q,
  output logic [KEY_BITS-1:0]                     evk_q
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

  // frame contents
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  occ_r, occ_nxt;
  logic                  ref_r, ref_nxt;

  // token stage
  csc_pkg::pkt_ctl_t     ctl_r, ctl_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [IW-1:0]         free_r, free_nxt;
  logic [VALUE_BITS-1:0] pval_r, pval_nxt;
  logic [KEY_BITS-1:0]   evk_r, evk_nxt;

  logic take_inj;
  logic is_act;

  assign take_inj = inj_ctl.valid && (inj_at == MY_IDX);
  assign is_act   = (CW'(CELL_IDX) < act);

  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    occ_nxt = occ_r;
    ref_nxt = ref_r;

    if (take_inj) begin
      ctl_nxt  = inj_ctl;
      idx_nxt  = '0;
      free_nxt = '0;
      pval_nxt = '0;
      evk_nxt  = '0;
    end else begin
      ctl_nxt  = prev_ctl;
      idx_nxt  = prev_idx;
      free_nxt = prev_free_idx;
      pval_nxt = prev_val;
      evk_nxt  = prev_evk;
    end

    if (ctl_nxt.valid && !ctl_nxt.sweep) begin
      // lookup: at most one occupied frame holds the key
      if (occ_r && (key_r == req_key) && !ctl_nxt.found) begin
        ctl_nxt.found = 1'b1;
        idx_nxt       = MY_IDX;
        ref_nxt       = 1'b1;
        if (req_action == csc_pkg::ACT_INSERT) begin
          val_nxt = req_value;
        end else begin
          pval_nxt = val_r;
        end
      end
      if (!ctl_nxt.free_found && !occ_r && is_act) begin
        ctl_nxt.free_found = 1'b1;
        free_nxt           = MY_IDX;
      end
    end else if (ctl_nxt.valid && ctl_nxt.sweep && !ctl_nxt.found && is_act) begin
      // second chance: clear and pass on, or evict here
      if (ref_r) begin
        ref_nxt = 1'b0;
      end else begin
        ctl_nxt.found = 1'b1;
        idx_nxt       = MY_IDX;
        evk_nxt       = key_r;
        key_nxt       = req_key;
        val_nxt       = req_value;
        ref_nxt       = 1'b1;
      end
    end

    // fill of a free frame
    if (wr_en && (wr_at == MY_IDX)) begin
      key_nxt = req_key;
      val_nxt = req_value;
      occ_nxt = 1'b1;
      ref_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      ref_r <= 1'b0;
      ctl_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      ref_r <= ref_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    idx_r  <= idx_nxt;
    free_r <= free_nxt;
    pval_r <= pval_nxt;
    evk_r  <= evk_nxt;
  end

  assign ctl_q      = ctl_r;
  assign idx_q      = idx_r;
  assign free_idx_q = free_r;
  assign val_q      = pval_r;
  assign evk_q      = evk_r;

endmodule

/* rtl/core/clock_sweep_cache.sv */
// clock_sweep_cache: top level, controller and the row of frame cells
// depends on csc_pkg and csc_cell

// Fully associative key/value cache of FRAMES frames with clock (second-chance)
// replacement. Each frame lives in a cell of a row; a token enters the row and
// moves one cell per clock, so every frame is visited by registered logic of its
// own. An item is accepted on in_valid & in_ready and gives exactly one result
// item. For an access, an update of a present key, or an insert into a free
// frame, the result is ready once the lookup token has walked the whole row. An
// insert that must evict adds a sweep token that starts at the hand and walks to
// the end of the row, and if it finds no clear reference bit there it restarts
// at frame 0 and walks the row once more. One item is processed at a time; the
// next is taken as soon as the result sits in the output register, even if that
// result has not yet been taken. cfg_wdata sets the active frame count (0 acts as
// 1, above FRAMES acts as FRAMES); write it only while idle. Reset clears
// occupancy, reference bits and the hand at once: no clearing pass, the block is
// ready in the cycle after reset.

module clock_sweep_cache #(
  parameter int FRAMES     = csc_pkg::FRAMES_DEF,
  parameter int KEY_BITS   = csc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = csc_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [csc_pkg::CFG_BITS-1:0] cfg_wdata,
  // input items
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_action,
  input  logic [KEY_BITS-1:0]          in_key,
  input  logic [VALUE_BITS-1:0]        in_new_value,
  // result items
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic [VALUE_BITS-1:0]        out_read_value,
  output logic [csc_pkg::FI_BITS-1:0]  out_frame_index,
  output logic                         out_evicted,
  output logic [KEY_BITS-1:0]          out_evicted_key
);

  localparam int IW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW   = $clog2(FRAMES + 1);
  localparam int FI_W = csc_pkg::FI_BITS;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_START  = 5'b00010,
    S_LOOK   = 5'b00100,
    S_SWEEP  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration and hand
  logic [csc_pkg::CFG_BITS-1:0] cfg_r;
  logic [CW-1:0]                act_c;
  logic [IW-1:0]                hand_r, hand_nxt;
  logic [IW-1:0]                start_c;
  logic [CW-1:0]                slot_inc_c;

  // held request
  logic                  req_action_r;
  logic [KEY_BITS-1:0]   req_key_r;
  logic [VALUE_BITS-1:0] req_value_r;

  // pending result
  logic                  res_hit_r, res_hit_nxt;
  logic [VALUE_BITS-1:0] res_rv_r, res_rv_nxt;
  logic [FI_W-1:0]       res_idx_r, res_idx_nxt;
  logic                  res_ev_r, res_ev_nxt;
  logic [KEY_BITS-1:0]   res_evk_r, res_evk_nxt;

  // output register
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [VALUE_BITS-1:0] out_rv_r;
  logic [FI_W-1:0]       out_idx_r;
  logic                  out_ev_r;
  logic [KEY_BITS-1:0]   out_evk_r;
  logic                  fin_go;

  // broadcast to the cells
  csc_pkg::pkt_ctl_t inj_ctl;
  logic [IW-1:0]     inj_at;
  logic              wr_en;
  logic [IW-1:0]     wr_at;

  // token row
  csc_pkg::pkt_ctl_t     ctl_w      [FRAMES];
  logic [IW-1:0]         idx_w      [FRAMES];
  logic [IW-1:0]         free_w     [FRAMES];
  logic [VALUE_BITS-1:0] val_w      [FRAMES];
  logic [KEY_BITS-1:0]   evk_w      [FRAMES];
  csc_pkg::pkt_ctl_t     prev_ctl_w [FRAMES];
  logic [IW-1:0]         prev_idx_w [FRAMES];
  logic [IW-1:0]         prev_free_w[FRAMES];
  logic [VALUE_BITS-1:0] prev_val_w [FRAMES];
  logic [KEY_BITS-1:0]   prev_evk_w [FRAMES];

  // token leaving the last cell
  csc_pkg::pkt_ctl_t     exit_ctl;
  logic [IW-1:0]         exit_idx;
  logic [IW-1:0]         exit_free;
  logic [VALUE_BITS-1:0] exit_val;
  logic [KEY_BITS-1:0]   exit_evk;

  assign exit_ctl  = ctl_w[FRAMES-1];
  assign exit_idx  = idx_w[FRAMES-1];
  assign exit_free = free_w[FRAMES-1];
  assign exit_val  = val_w[FRAMES-1];
  assign exit_evk  = evk_w[FRAMES-1];

  // active frame count, clamped to 1..FRAMES
  always_comb begin
    if (cfg_r == '0) begin
      act_c = CW'(1);
    end else if (int'(cfg_r) > FRAMES) begin
      act_c = CW'(FRAMES);
    end else begin
      act_c = CW'(cfg_r);
    end
  end

  // sweep restarts at frame 0 when the hand sits beyond the active frames
  assign start_c    = (CW'(hand_r) >= act_c) ? '0 : hand_r;
  assign slot_inc_c = CW'(exit_idx) + CW'(1);

  // row of cells; the first one sees an empty stage behind it
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_ctl_w[g]  = '0;
      assign prev_idx_w[g]  = '0;
      assign prev_free_w[g] = '0;
      assign prev_val_w[g]  = '0;
      assign prev_evk_w[g]  = '0;
    end else begin : g_link
      assign prev_ctl_w[g]  = ctl_w[g-1];
      assign prev_idx_w[g]  = idx_w[g-1];
      assign prev_free_w[g] = free_w[g-1];
      assign prev_val_w[g]  = val_w[g-1];
      assign prev_evk_w[g]  = evk_w[g-1];
    end

    csc_cell #(
      .FRAMES     (FRAMES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .CELL_IDX   (g)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .act           (act_c),
      .req_action    (req_action_r),
      .req_key       (req_key_r),
      .req_value     (req_value_r),
      .inj_ctl       (inj_ctl),
      .inj_at        (inj_at),
      .wr_en         (wr_en),
      .wr_at         (wr_at),
      .prev_ctl      (prev_ctl_w[g]),
      .prev_idx      (prev_idx_w[g]),
      .prev_free_idx (prev_free_w[g]),
      .prev_val      (prev_val_w[g]),
      .prev_evk      (prev_evk_w[g]),
      .ctl_q         (ctl_w[g]),
      .idx_q         (idx_w[g]),
      .free_idx_q    (free_w[g]),
      .val_q         (val_w[g]),
      .evk_q         (evk_w[g])
    );
  end

  assign in_ready = (state_r == S_IDLE);
  assign fin_go   = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  // controller: launch tokens, decide on their exit, stage the result
  always_comb begin
    state_nxt   = state_r;
    hand_nxt    = hand_r;
    inj_ctl     = '0;
    inj_at      = '0;
    wr_en       = 1'b0;
    wr_at       = exit_free;
    res_hit_nxt = res_hit_r;
    res_rv_nxt  = res_rv_r;
    res_idx_nxt = res_idx_r;
    res_ev_nxt  = res_ev_r;
    res_evk_nxt = res_evk_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_START;
        end
      end

      S_START: begin
        // lookup token enters at frame 0
        inj_ctl.valid = 1'b1;
        inj_at        = '0;
        state_nxt     = S_LOOK;
      end

      S_LOOK: begin
        if (exit_ctl.valid) begin
          res_hit_nxt = 1'b0;
          res_rv_nxt  = '0;
          res_idx_nxt = '0;
          res_ev_nxt  = 1'b0;
          res_evk_nxt = '0;
          state_nxt   = S_FINISH;
          if (exit_ctl.found) begin
            // hit: the cell already set its reference bit and took the value
            res_hit_nxt = 1'b1;
            res_rv_nxt  = exit_val;
            res_idx_nxt = FI_W'(exit_idx);
          end else if (req_action_r == csc_pkg::ACT_ACCESS) begin
            // access miss leaves everything as it was
          end else if (exit_ctl.free_found) begin
            wr_en       = 1'b1;
            res_idx_nxt = FI_W'(exit_free);
          end else begin
            // every active frame occupied: start the sweep at the hand
            inj_ctl.valid = 1'b1;
            inj_ctl.sweep = 1'b1;
            inj_at        = start_c;
            state_nxt     = S_SWEEP;
          end
        end
      end

      S_SWEEP: begin
        if (exit_ctl.valid) begin
          if (exit_ctl.found) begin
            res_idx_nxt = FI_W'(exit_idx);
            res_ev_nxt  = 1'b1;
            res_evk_nxt = exit_evk;
            hand_nxt    = (slot_inc_c == act_c) ? '0 : IW'(slot_inc_c);
            state_nxt   = S_FINISH;
          end else begin
            // ran off the active frames: wrap round to frame 0
            inj_ctl.valid = 1'b1;
            inj_ctl.sweep = 1'b1;
            inj_at        = '0;
          end
        end
      end

      S_FINISH: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= csc_pkg::CFG_RESET;
      hand_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hand_r  <= hand_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_action_r <= in_action;
      req_key_r    <= in_key;
      req_value_r  <= in_new_value;
    end
    res_hit_r <= res_hit_nxt;
    res_rv_r  <= res_rv_nxt;
    res_idx_r <= res_idx_nxt;
    res_ev_r  <= res_ev_nxt;
    res_evk_r <= res_evk_nxt;
    if (fin_go) begin
      out_hit_r <= res_hit_r;
      out_rv_r  <= res_rv_r;
      out_idx_r <= res_idx_r;
      out_ev_r  <= res_ev_r;
      out_evk_r <= res_evk_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_rv_r;
  assign out_frame_index = out_idx_r;
  assign out_evicted     = out_ev_r;
  assign out_evicted_key = out_evk_r;

endmodule

/* rtl/core/csc_checker.sv */
// csc_checker: port level assertions for clock_sweep_cache, bound to the top
// depends on csc_pkg

module csc_checker #(
  parameter int KEY_BITS   = csc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = csc_pkg::VALUE_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_hit,
  input logic [VALUE_BITS-1:0]        out_read_value,
  input logic [csc_pkg::FI_BITS-1:0]  out_frame_index,
  input logic                         out_evicted,
  input logic [KEY_BITS-1:0]          out_evicted_key
);

  // one item at a time: busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again straight after an accepted item");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_index) &&
      $stable(out_evicted_key) && $stable(out_read_value))
    else $error("stalled result item changed");

  // an eviction is never a hit and returns no value
  a_evict_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit && (out_read_value == '0))
    else $error("eviction reported together with a hit");

  // evicted key only shown on eviction
  a_evk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> (out_evicted_key == '0))
    else $error("evicted key without eviction");

endmodule

bind clock_sweep_cache csc_checker #(
  .KEY_BITS   (KEY_BITS),
  .VALUE_BITS (VALUE_BITS)
) u_csc_checker (.*);
